/* hw/rtl/sfr_pkg.sv */
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared types and constants of the streaming find-and-replace block.
// ----------------------------------------------------------------------------
package sfr_pkg;

  localparam int unsigned RegWidth  = 64;
  localparam int unsigned LenWidth  = 5;
  localparam int unsigned IdxWidth  = 3;

  // Longest pattern and replacement held by the configuration registers.
  localparam int unsigned PatternMax     = 16;
  localparam int unsigned ReplacementMax = 16;

  // Configuration register indexes.
  localparam logic [IdxWidth-1:0] RegPatLen = 3'd0;
  localparam logic [IdxWidth-1:0] RegPatLo  = 3'd1;
  localparam logic [IdxWidth-1:0] RegPatHi  = 3'd2;
  localparam logic [IdxWidth-1:0] RegRepLen = 3'd3;
  localparam logic [IdxWidth-1:0] RegRepLo  = 3'd4;
  localparam logic [IdxWidth-1:0] RegRepHi  = 3'd5;

  // Input word as it travels through the queue.
  typedef struct packed {
    logic [7:0] text_byte;
    logic       final_byte;
  } in_word_t;

  // One result word.
  typedef struct packed {
    logic [7:0] result_byte;
    logic       has_byte;
    logic       end_of_text;
  } out_word_t;

  // Back-end sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FALL,
    ST_CHECK,
    ST_REPL,
    ST_FLUSH,
    ST_MARK,
    ST_BUILD
  } state_t;

endpackage

/* hw/rtl/sfr_if.sv */
// ----------------------------------------------------------------------------
// sfr_if
// Valid/ready channel carrying one payload word.
// ----------------------------------------------------------------------------
interface sfr_if #(
  parameter type word_t = logic
);
  logic  valid;
  logic  ready;
  word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* hw/rtl/stream_find_replace_all_top.sv */
// ----------------------------------------------------------------------------
// stream_find_replace_all_top
// Streaming find-and-replace of every leftmost non-overlapping occurrence.
// ----------------------------------------------------------------------------
// Words enter a two-entry queue and are handled one at a time by a sequencer
// that emits at most one result word per cycle. A word is taken from the
// queue in IDLE and then matched in CHECK; with an empty pattern a word
// passes straight through from IDLE. Each failure fallback re-emits the
// dropped pattern bytes in FALL and then matches again, a completed match
// emits the replacement bytes in REPL, and a final byte flushes the held
// pattern bytes in FLUSH, with MARK closing the text. Every result waits
// while the output is stalled. After a pattern write the failure table is
// rebuilt in BUILD; the user must write configuration only while no word is
// in flight, and the block itself does not enforce this.
module stream_find_replace_all_top
  import sfr_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic [IdxWidth-1:0] cfg_index,
  input  logic [RegWidth-1:0] cfg_data,
  sfr_if.sink                 text_in,
  sfr_if.source               result_out
);

  in_word_t  q_word;
  logic      q_full, q_nonempty, q_pop;
  in_word_t  front_word;
  out_word_t res_word;

  // Front end: accept words into the queue.
  assign text_in.ready = !q_full;
  assign front_word    = text_in.data;

  sfr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (text_in.valid && !q_full),
    .push_word (front_word),
    .full      (q_full),
    .pop       (q_pop),
    .pop_word  (q_word),
    .not_empty (q_nonempty)
  );

  sfr_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (q_nonempty),
    .in_word   (q_word),
    .in_pop    (q_pop),
    .out_valid (result_out.valid),
    .out_word  (res_word),
    .out_ready (result_out.ready)
  );

  assign result_out.data = res_word;

endmodule

/* hw/rtl/sfr_queue.sv */
// ----------------------------------------------------------------------------
// sfr_queue
// Two-entry queue between the front end and the back end.
// ----------------------------------------------------------------------------
module sfr_queue
  import sfr_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  in_word_t push_word,
  output logic     full,
  input  logic     pop,
  output in_word_t pop_word,
  output logic     not_empty
);

  in_word_t   slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  assign full      = (fill == 2'd2);
  assign not_empty = (fill != 2'd0);
  assign pop_word  = slots[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_word;
  end

endmodule

/* hw/rtl/sfr_engine.sv */
// ----------------------------------------------------------------------------
// sfr_engine
// Back end: matcher with failure table, replacement and flush sequencing.
// ----------------------------------------------------------------------------
module sfr_engine
  import sfr_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [IdxWidth-1:0]    cfg_index,
  input  logic [RegWidth-1:0]    cfg_data,
  input  logic                   in_valid,
  input  in_word_t               in_word,
  output logic                   in_pop,
  output logic                   out_valid,
  output out_word_t              out_word,
  input  logic                   out_ready
);

  localparam int unsigned CntW = $clog2(PatternMax + 1);
  localparam int unsigned PIdxW = (PatternMax > 1) ? $clog2(PatternMax) : 1;
  localparam int unsigned RCntW = $clog2(ReplacementMax + 1);

  logic [LenWidth-1:0] pat_len_reg;
  logic [LenWidth-1:0] rep_len_reg;
  logic [63:0]         pat_lo, pat_hi, rep_lo, rep_hi;
  logic [CntW-1:0]     fail_tab [PatternMax];

  state_t          state, state_next;
  logic [CntW-1:0] q;
  logic [CntW-1:0] nq;
  logic [CntW-1:0] idx;
  logic [CntW-1:0] bi;
  logic [CntW-1:0] bk;
  logic [7:0]      cur_c;
  logic            cur_last;
  logic            emitted;
  logic            out_busy;

  logic [CntW-1:0]  m;
  logic [RCntW-1:0] r;

  // Byte pickers; bytes past the sixteen held read as zero.
  function automatic logic [7:0] pick(input logic [63:0] lo, input logic [63:0] hi,
                                      input logic [6:0] i);
    logic [7:0] b;
    b = 8'd0;
    if (i < 7'd8) b = lo[i[2:0]*8 +: 8];
    else if (i < 7'd16) b = hi[i[2:0]*8 +: 8];
    return b;
  endfunction

  always_comb begin
    m = (pat_len_reg > LenWidth'(PatternMax)) ? CntW'(PatternMax) : CntW'(pat_len_reg);
    r = (rep_len_reg > LenWidth'(ReplacementMax)) ? RCntW'(ReplacementMax)
                                                  : RCntW'(rep_len_reg);
  end

  logic [7:0] pat_q, pat_idx, pat_bi, pat_bk, rep_idx;
  assign pat_q   = pick(pat_lo, pat_hi, 7'(q));
  assign pat_idx = pick(pat_lo, pat_hi, 7'(idx));
  assign pat_bi  = pick(pat_lo, pat_hi, 7'(bi));
  assign pat_bk  = pick(pat_lo, pat_hi, 7'(bk));
  assign rep_idx = pick(rep_lo, rep_hi, 7'(idx));

  logic pat_cfg;
  assign pat_cfg = cfg_write && (cfg_index == RegPatLen || cfg_index == RegPatLo ||
                                 cfg_index == RegPatHi);

  logic cur_last_in;
  assign cur_last_in = in_word.final_byte;

  logic q_eff_zero;
  logic [CntW-1:0] fail_prev;
  assign fail_prev = (q == '0) ? '0 : fail_tab[PIdxW'(q - 1'b1)];
  logic [CntW-1:0] fail_bk;
  assign fail_bk = (bk == '0) ? '0 : fail_tab[PIdxW'(bk - 1'b1)];
  assign q_eff_zero = (q == '0);

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid && !out_busy) begin
          if (m == '0) state_next = cur_last_in ? ST_MARK : ST_IDLE;
          else state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (!q_eff_zero && pat_q != cur_c) state_next = ST_FALL;
        else if (pat_q == cur_c && q + 1'b1 == m) state_next = ST_REPL;
        else if (pat_q != cur_c && out_busy) state_next = ST_CHECK;
        else state_next = cur_last ? ST_FLUSH : ST_IDLE;
      end
      ST_FALL: begin
        if (!out_busy && idx + 1'b1 >= q - nq) state_next = ST_CHECK;
      end
      ST_REPL: begin
        if (RCntW'(idx) >= r) state_next = cur_last ? ST_MARK : ST_IDLE;
        else if (!out_busy && RCntW'(idx) + 1'b1 >= r)
          state_next = cur_last ? ST_MARK : ST_IDLE;
      end
      ST_FLUSH: begin
        if (idx >= q) state_next = ST_MARK;
        else if (!out_busy && idx + 1'b1 >= q) state_next = ST_MARK;
      end
      ST_MARK: begin
        if (!out_busy) state_next = ST_IDLE;
      end
      ST_BUILD: begin
        if (bi >= m) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign in_pop = (state == ST_IDLE) && in_valid && !out_busy && !pat_cfg;

  // Output register loads: decide what word is produced this cycle.
  // A full match can never follow a fallback, since the match length after a
  // fallback stays at least one short of the pattern. So the last word of a
  // final byte is always known when it is loaded, and MARK only has to add a
  // marker when nothing at all was produced.
  logic      load;
  out_word_t load_word;
  always_comb begin
    load = 1'b0;
    load_word = '{result_byte: 8'd0, has_byte: 1'b0, end_of_text: 1'b0};
    unique case (state)
      ST_IDLE: begin
        if (in_pop && m == '0) begin
          load = 1'b1;
          load_word = '{result_byte: in_word.text_byte, has_byte: 1'b1,
                        end_of_text: in_word.final_byte};
        end
      end
      ST_CHECK: begin
        if (!out_busy && q_eff_zero && pat_q != cur_c) begin
          load = 1'b1;
          load_word = '{result_byte: cur_c, has_byte: 1'b1,
                        end_of_text: cur_last && q == '0};
        end
      end
      ST_FALL: begin
        if (!out_busy) begin
          load = 1'b1;
          load_word = '{result_byte: pat_idx, has_byte: 1'b1, end_of_text: 1'b0};
        end
      end
      ST_REPL: begin
        if (!out_busy && RCntW'(idx) < r) begin
          load = 1'b1;
          load_word = '{result_byte: rep_idx, has_byte: 1'b1,
                        end_of_text: cur_last && RCntW'(idx) + 1'b1 == r};
        end
      end
      ST_FLUSH: begin
        if (!out_busy && idx < q) begin
          load = 1'b1;
          load_word = '{result_byte: pat_idx, has_byte: 1'b1,
                        end_of_text: idx + 1'b1 == q};
        end
      end
      ST_MARK: begin
        if (!out_busy && !emitted) begin
          load = 1'b1;
          load_word = '{result_byte: 8'd0, has_byte: 1'b0, end_of_text: 1'b1};
        end
      end
      ST_BUILD: load = 1'b0;
      default: load = 1'b0;
    endcase
  end

  // Output register; a pending word is held until taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_valid && out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) out_word <= load_word;
  end

  assign out_busy = out_valid && !out_ready;

  // Sequencer registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else if (pat_cfg) begin
      state <= ST_BUILD;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q       <= '0;
      idx     <= '0;
      nq      <= '0;
      emitted <= 1'b0;
      bi      <= '0;
      bk      <= '0;
    end else if (pat_cfg) begin
      q  <= '0;
      bi <= CntW'(1);
      bk <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          idx <= '0;
          emitted <= 1'b0;
          if (in_pop) begin
            cur_c    <= in_word.text_byte;
            cur_last <= in_word.final_byte;
            if (q >= m) q <= '0;
            if (m == '0) emitted <= 1'b1;
          end
        end
        ST_CHECK: begin
          idx <= '0;
          if (!q_eff_zero && pat_q != cur_c) begin
            nq <= fail_prev;
          end else if (pat_q == cur_c) begin
            if (q + 1'b1 == m) q <= '0;
            else q <= q + 1'b1;
          end else if (!out_busy) begin
            emitted <= 1'b1;
          end
        end
        ST_FALL: begin
          if (!out_busy) begin
            emitted <= 1'b1;
            if (idx + 1'b1 >= q - nq) begin
              idx <= '0;
              q   <= nq;
            end else begin
              idx <= idx + 1'b1;
            end
          end
        end
        ST_REPL: begin
          if (RCntW'(idx) >= r) idx <= '0;
          else if (!out_busy) begin
            emitted <= 1'b1;
            idx <= (RCntW'(idx) + 1'b1 >= r) ? '0 : idx + 1'b1;
          end
        end
        ST_FLUSH: begin
          if (idx >= q) begin
            idx <= '0;
            q <= '0;
          end else if (!out_busy) begin
            emitted <= 1'b1;
            if (idx + 1'b1 >= q) begin
              idx <= '0;
              q <= '0;
            end else idx <= idx + 1'b1;
          end
        end
        ST_MARK: begin
          if (!out_busy) q <= '0;
        end
        ST_BUILD: begin
          if (bi < m) begin
            if (bk != '0 && pat_bi != pat_bk) begin
              bk <= fail_bk;
            end else begin
              bk <= (pat_bi == pat_bk) ? bk + 1'b1 : bk;
              bi <= bi + 1'b1;
            end
          end
        end
        default: q <= q;
      endcase
    end
  end

  // Failure table, built one pattern position at a time after each pattern write.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < PatternMax; j++) fail_tab[j] <= '0;
    end else if (pat_cfg) begin
      for (int j = 0; j < PatternMax; j++) fail_tab[j] <= '0;
    end else if (state == ST_BUILD && bi < m) begin
      if (!(bk != '0 && pat_bi != pat_bk))
        fail_tab[PIdxW'(bi)] <= (pat_bi == pat_bk) ? bk + 1'b1 : bk;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      pat_len_reg <= '0;
      rep_len_reg <= '0;
      pat_lo <= '0;
      pat_hi <= '0;
      rep_lo <= '0;
      rep_hi <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        RegPatLen: pat_len_reg <= cfg_data[LenWidth-1:0];
        RegPatLo:  pat_lo <= cfg_data;
        RegPatHi:  pat_hi <= cfg_data;
        RegRepLen: rep_len_reg <= cfg_data[LenWidth-1:0];
        RegRepLo:  rep_lo <= cfg_data;
        RegRepHi:  rep_hi <= cfg_data;
        default:   pat_lo <= pat_lo;
      endcase
    end
  end

endmodule
